/* hw/rtl/ssp_pkg.sv */
package ssp_pkg;

    localparam int CHAR_W = 8;
    localparam int SIZE_W = 63;

    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_KILO = 8'h6B;  // 'k'
    localparam logic [CHAR_W-1:0] CH_MEGA = 8'h4D;  // 'M'
    localparam logic [CHAR_W-1:0] CH_GIGA = 8'h47;  // 'G'
    localparam logic [CHAR_W-1:0] CH_BYTE = 8'h42;  // 'B'
    localparam logic [CHAR_W-1:0] CH_BIT  = 8'h62;  // 'b'

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_SUFFIX = 4'b0100,
        PH_HELD   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        logic [SIZE_W-1:0] acc;
        logic              ovf;
        logic [SIZE_W-1:0] held_val;
        logic              held_err;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:    PH_START,
        acc:      '0,
        ovf:      1'b0,
        held_val: '0,
        held_err: 1'b0
    };

    typedef struct packed {
        logic              emit;
        logic              ok;
        logic [SIZE_W-1:0] bytes;
    } t_result;

endpackage

/* hw/rtl/ssp_char_if.sv */
interface ssp_char_if;
    logic                       valid;
    logic                       ready;
    logic [ssp_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

/* hw/rtl/ssp_size_if.sv */
interface ssp_size_if;
    logic                       valid;
    logic                       ready;
    logic                       size_ok;
    logic [ssp_pkg::SIZE_W-1:0] size_bytes;

    modport source (output valid, output size_ok, output size_bytes, input ready);
    modport sink   (input valid, input size_ok, input size_bytes, output ready);
endinterface

/* hw/rtl/size_suffix_string_parser_core.sv */
// Size string parser. Characters arrive one per beat on i_char; a zero byte
// ends the string and produces exactly one beat on o_size carrying size_ok and
// the byte count (zero on error). Digits, an optional k/M/G scale and an
// optional B (bytes) or b (bits, rounded up to bytes) are accepted; a missing
// number reads as zero and text after B/b is ignored. Any other character, an
// empty string or a value above 2^63-1 gives size_ok = 0. The block takes one
// character every cycle; only a further terminator stalls, in the input
// register, until the result waiting on o_size.ready is taken. The parse
// state, with its multiply-by-ten accumulate, comes combinationally from the
// input register; results go out through an output register to o_size.
module size_suffix_string_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssp_char_if.sink   i_char,
    ssp_size_if.source o_size
);

    logic                       r_in_valid;
    logic [ssp_pkg::CHAR_W-1:0] r_char;
    ssp_pkg::t_state            r_st;
    ssp_pkg::t_state            n_st;
    ssp_pkg::t_result           step_res;
    logic                       r_out_valid;
    logic                       r_out_ok;
    logic [ssp_pkg::SIZE_W-1:0] r_out_bytes;
    logic                       proceed;

    ssp_step u_step (
        .i_st   (r_st),
        .i_char (r_char),
        .o_st   (n_st),
        .o_res  (step_res)
    );

    assign proceed      = r_in_valid && (!step_res.emit || !r_out_valid || o_size.ready);
    assign i_char.ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ssp_pkg::ST_RESET;
        end else if (proceed) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_size.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && step_res.emit) begin
            r_out_ok    <= step_res.ok;
            r_out_bytes <= step_res.bytes;
        end
    end

    assign o_size.valid      = r_out_valid;
    assign o_size.size_ok    = r_out_ok;
    assign o_size.size_bytes = r_out_bytes;

endmodule

/* hw/rtl/ssp_step.sv */
module ssp_step (
    input  ssp_pkg::t_state                i_st,
    input  logic [ssp_pkg::CHAR_W-1:0]     i_char,
    output ssp_pkg::t_state                o_st,
    output ssp_pkg::t_result               o_res
);

    localparam int SW = ssp_pkg::SIZE_W;

    logic          is_digit;
    logic [3:0]    digit;
    logic [SW+3:0] prod;
    logic          dig_ovf;
    logic          k_ovf;
    logic          m_ovf;
    logic          g_ovf;
    logic [SW:0]   bits_sum;
    logic [SW-1:0] bits_bytes;

    assign is_digit   = (i_char >= ssp_pkg::CH_ZERO) && (i_char <= ssp_pkg::CH_NINE);
    assign digit      = 4'(i_char - ssp_pkg::CH_ZERO);
    // acc * 10 + d, checked against 2^63-1
    assign prod       = ({4'b0, i_st.acc} << 3) + ({4'b0, i_st.acc} << 1)
                        + {{SW{1'b0}}, digit};
    assign dig_ovf    = |prod[SW+3:SW];
    assign k_ovf      = |i_st.acc[SW-1:SW-10];
    assign m_ovf      = |i_st.acc[SW-1:SW-20];
    assign g_ovf      = |i_st.acc[SW-1:SW-30];
    assign bits_sum   = {1'b0, i_st.acc} + {{(SW-2){1'b0}}, 3'd7};
    assign bits_bytes = {2'b00, bits_sum[SW:3]};

    always_comb begin
        o_st        = i_st;
        o_res.emit  = 1'b0;
        o_res.ok    = 1'b0;
        o_res.bytes = '0;

        if (i_char == ssp_pkg::CH_NUL) begin
            o_res.emit = 1'b1;
            unique case (i_st.phase)
                ssp_pkg::PH_START: begin
                    o_res.ok = 1'b0;
                end
                ssp_pkg::PH_HELD: begin
                    o_res.ok    = !i_st.held_err;
                    o_res.bytes = i_st.held_val;
                end
                default: begin
                    o_res.ok    = !i_st.ovf;
                    o_res.bytes = i_st.ovf ? '0 : i_st.acc;
                end
            endcase
            o_st = ssp_pkg::ST_RESET;
        end else begin
            unique case (i_st.phase)
                ssp_pkg::PH_HELD: begin
                end
                ssp_pkg::PH_SUFFIX: begin
                    o_st.phase = ssp_pkg::PH_HELD;
                    if (i_char == ssp_pkg::CH_BYTE) begin
                        o_st.held_err = i_st.ovf;
                        o_st.held_val = i_st.ovf ? '0 : i_st.acc;
                    end else if (i_char == ssp_pkg::CH_BIT) begin
                        o_st.held_err = i_st.ovf;
                        o_st.held_val = i_st.ovf ? '0 : bits_bytes;
                    end else begin
                        o_st.held_err = 1'b1;
                        o_st.held_val = '0;
                    end
                end
                ssp_pkg::PH_START, ssp_pkg::PH_DIGITS: begin
                    if (is_digit) begin
                        o_st.phase = ssp_pkg::PH_DIGITS;
                        if (!i_st.ovf) begin
                            if (dig_ovf) begin
                                o_st.ovf = 1'b1;
                            end else begin
                                o_st.acc = prod[SW-1:0];
                            end
                        end
                    end else if (i_char == ssp_pkg::CH_KILO) begin
                        o_st.phase = ssp_pkg::PH_SUFFIX;
                        if (k_ovf) begin
                            o_st.ovf = 1'b1;
                        end else begin
                            o_st.acc = i_st.acc << 10;
                        end
                    end else if (i_char == ssp_pkg::CH_MEGA) begin
                        o_st.phase = ssp_pkg::PH_SUFFIX;
                        if (m_ovf) begin
                            o_st.ovf = 1'b1;
                        end else begin
                            o_st.acc = i_st.acc << 20;
                        end
                    end else if (i_char == ssp_pkg::CH_GIGA) begin
                        o_st.phase = ssp_pkg::PH_SUFFIX;
                        if (g_ovf) begin
                            o_st.ovf = 1'b1;
                        end else begin
                            o_st.acc = i_st.acc << 30;
                        end
                    end else if (i_char == ssp_pkg::CH_BYTE) begin
                        o_st.phase    = ssp_pkg::PH_HELD;
                        o_st.held_err = i_st.ovf;
                        o_st.held_val = i_st.ovf ? '0 : i_st.acc;
                    end else if (i_char == ssp_pkg::CH_BIT) begin
                        o_st.phase    = ssp_pkg::PH_HELD;
                        o_st.held_err = i_st.ovf;
                        o_st.held_val = i_st.ovf ? '0 : bits_bytes;
                    end else begin
                        o_st.phase    = ssp_pkg::PH_HELD;
                        o_st.held_err = 1'b1;
                        o_st.held_val = '0;
                    end
                end
                default: begin
                    o_st = ssp_pkg::ST_RESET;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ssp_chk.sv */
module ssp_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [ssp_pkg::CHAR_W-1:0] i_char_code,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_size_ok,
    input logic [ssp_pkg::SIZE_W-1:0] i_size_bytes
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_size_ok) |-> (i_size_bytes == '0))
        else $error("error beat with nonzero size");

    a_beat_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |->
            $past(i_in_valid && i_in_ready && (i_char_code == ssp_pkg::CH_NUL), 2))
        else $error("result beat without terminator two cycles before");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_size_ok) && $stable(i_size_bytes)))
        else $error("stalled result beat changed");

endmodule

bind size_suffix_string_parser_core ssp_chk u_ssp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_char.valid),
    .i_in_ready   (i_char.ready),
    .i_char_code  (i_char.char_code),
    .i_out_valid  (o_size.valid),
    .i_out_ready  (o_size.ready),
    .i_size_ok    (o_size.size_ok),
    .i_size_bytes (o_size.size_bytes)
);
